FILE: design/hthd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hthd_pkg - shared types and constants of the header/tail packet deframer
// Widths of the byte, index and length fields, register map, reset values and
// the command word passed from the parser to the payload engine.
// ----------------------------------------------------------------------------
package hthd_pkg;

  localparam int BYTE_W = 8;
  localparam int IDX_W  = 6;
  localparam int LEN_W  = 7;

  // command queue between parser and payload engine
  localparam int Q_DEPTH = 2;
  localparam int Q_AW    = 1;

  // register map (index = paddr[3:2])
  localparam int CFG_AW = 4;
  localparam logic [1:0] CFG_HEADER_FIRST   = 2'd0;
  localparam logic [1:0] CFG_HEADER_SECOND  = 2'd1;
  localparam logic [1:0] CFG_TRAILER_FIRST  = 2'd2;
  localparam logic [1:0] CFG_TRAILER_SECOND = 2'd3;

  localparam logic [BYTE_W-1:0] HEADER_FIRST_RST   = 8'd67;
  localparam logic [BYTE_W-1:0] HEADER_SECOND_RST  = 8'd77;
  localparam logic [BYTE_W-1:0] TRAILER_FIRST_RST  = 8'd13;
  localparam logic [BYTE_W-1:0] TRAILER_SECOND_RST = 8'd10;

  typedef struct packed {
    logic [BYTE_W-1:0] header_first;
    logic [BYTE_W-1:0] header_second;
    logic [BYTE_W-1:0] trailer_first;
    logic [BYTE_W-1:0] trailer_second;
  } cfg_t;

  typedef enum logic {
    CMD_STORE   = 1'b0,
    CMD_DELIVER = 1'b1
  } cmd_op_t;

  // STORE: data at payload position count; DELIVER: emit count bytes
  typedef struct packed {
    cmd_op_t           op;
    logic [BYTE_W-1:0] data;
    logic [LEN_W-1:0]  count;
  } cmd_t;

endpackage

FILE: design/header_tail_packet_deframer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// header_tail_packet_deframer - two-byte header / two-byte trailer deframer
// Recovers packets from a received byte stream and emits their payload.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one received byte per valid/ready transfer.
//   out_* : one result per transfer: payload byte, index, packet length,
//           empty mark and last mark. A confirmed empty packet gives a single
//           result with empty and last set.
//   APB   : four 8-bit match registers at byte addresses 0, 4, 8 and 12;
//           the user writes them only while the block is idle (unchecked).
// Throughput: the parser takes one byte per cycle while its two-entry command
//   queue has room. Stores drain at one per cycle while the engine is idle; a
//   confirmed packet is emitted one result at a time (buffer memory read, then
//   output register), and while the engine drains it further bytes back up in
//   the queue and then stall in_ready.
// Path: after the second trailer byte is taken, the first result passes the
//   queue, drain state, memory read register and output register in turn.
// Reset: rst_n (synchronous) returns the parser to header hunting, empties
//   the queue and the output register and restores the register defaults.
// A stalled receiver holds the output register; the engine then waits.
// ----------------------------------------------------------------------------
module header_tail_packet_deframer #(
  parameter int MAX_PAYLOAD = 64
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // byte input
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [hthd_pkg::BYTE_W-1:0]    in_rx_byte,
  // result output
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [hthd_pkg::BYTE_W-1:0]    out_payload_byte,
  output logic [hthd_pkg::IDX_W-1:0]     out_byte_index,
  output logic [hthd_pkg::LEN_W-1:0]     out_packet_length,
  output logic                           out_empty_packet,
  output logic                           out_last_of_packet,
  // configuration
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [hthd_pkg::CFG_AW-1:0]    paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);

  hthd_pkg::cfg_t cfg_r;
  hthd_pkg::cmd_t push_cmd, head;
  logic           push, pop, q_empty, q_full, cfg_wr;

  // register file
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.header_first   <= hthd_pkg::HEADER_FIRST_RST;
      cfg_r.header_second  <= hthd_pkg::HEADER_SECOND_RST;
      cfg_r.trailer_first  <= hthd_pkg::TRAILER_FIRST_RST;
      cfg_r.trailer_second <= hthd_pkg::TRAILER_SECOND_RST;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        hthd_pkg::CFG_HEADER_FIRST:   cfg_r.header_first   <= pwdata[7:0];
        hthd_pkg::CFG_HEADER_SECOND:  cfg_r.header_second  <= pwdata[7:0];
        hthd_pkg::CFG_TRAILER_FIRST:  cfg_r.trailer_first  <= pwdata[7:0];
        hthd_pkg::CFG_TRAILER_SECOND: cfg_r.trailer_second <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // read-back
  always_comb begin
    unique case (paddr[3:2])
      hthd_pkg::CFG_HEADER_FIRST:   prdata = {24'd0, cfg_r.header_first};
      hthd_pkg::CFG_HEADER_SECOND:  prdata = {24'd0, cfg_r.header_second};
      hthd_pkg::CFG_TRAILER_FIRST:  prdata = {24'd0, cfg_r.trailer_first};
      hthd_pkg::CFG_TRAILER_SECOND: prdata = {24'd0, cfg_r.trailer_second};
      default:                      prdata = '0;
    endcase
  end

  hthd_front #(.MAX_PAYLOAD(MAX_PAYLOAD)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_i      (cfg_r),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_rx_byte (in_rx_byte),
    .q_full_i   (q_full),
    .push_o     (push),
    .push_cmd_o (push_cmd)
  );

  hthd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_i     (push),
    .push_cmd_i (push_cmd),
    .pop_i      (pop),
    .head_o     (head),
    .empty_o    (q_empty),
    .full_o     (q_full)
  );

  hthd_back #(.MAX_PAYLOAD(MAX_PAYLOAD)) u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .head_i             (head),
    .empty_i            (q_empty),
    .pop_o              (pop),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_payload_byte   (out_payload_byte),
    .out_byte_index     (out_byte_index),
    .out_packet_length  (out_packet_length),
    .out_empty_packet   (out_empty_packet),
    .out_last_of_packet (out_last_of_packet)
  );

`ifndef SYNTH
  // the parser never writes a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !q_full) else $error("command queue overflow");

  // the engine never pops an empty queue
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !q_empty) else $error("command queue underflow");

  // an empty packet result is a lone, zero-length last result
  a_empty_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_empty_packet |-> out_last_of_packet && out_packet_length == '0)
    else $error("malformed empty packet result");

  // a payload result lies inside its packet
  a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_empty_packet |->
      ({1'b0, out_byte_index} < out_packet_length))
    else $error("byte index beyond packet length");
`endif

endmodule

FILE: design/hthd_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hthd_front - byte parser of the deframer
// Hunts for the header, counts payload bytes, checks the trailer and issues
// store and deliver commands into the command queue.
// ----------------------------------------------------------------------------
module hthd_front #(
  parameter int MAX_PAYLOAD = 64
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  hthd_pkg::cfg_t             cfg_i,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [hthd_pkg::BYTE_W-1:0] in_rx_byte,
  input  logic                       q_full_i,
  output logic                       push_o,
  output hthd_pkg::cmd_t             push_cmd_o
);

  typedef enum logic [3:0] {
    PH_HUNT_FIRST  = 4'b0001,
    PH_HUNT_SECOND = 4'b0010,
    PH_PAYLOAD     = 4'b0100,
    PH_TRAILER     = 4'b1000
  } phase_t;

  localparam logic [hthd_pkg::LEN_W-1:0] MAX_LEN = hthd_pkg::LEN_W'(MAX_PAYLOAD);

  phase_t                      phase_r, phase_nxt;
  logic [hthd_pkg::LEN_W-1:0]  cnt_r, cnt_nxt;
  logic                        accept;

  // one byte transfer per cycle while the queue has room
  assign in_ready = !q_full_i;
  assign accept   = in_valid && in_ready;

  // parser next state and command issue
  always_comb begin
    phase_nxt  = phase_r;
    cnt_nxt    = cnt_r;
    push_o     = 1'b0;
    push_cmd_o = '{op: hthd_pkg::CMD_STORE, data: in_rx_byte, count: cnt_r};
    if (accept) begin
      unique case (phase_r)
        PH_HUNT_FIRST: begin
          if (in_rx_byte == cfg_i.header_first) phase_nxt = PH_HUNT_SECOND;
        end
        PH_HUNT_SECOND: begin
          // second header byte wins over a repeated first one
          if (in_rx_byte == cfg_i.header_second) begin
            phase_nxt = PH_PAYLOAD;
            cnt_nxt   = '0;
          end else if (in_rx_byte != cfg_i.header_first) begin
            phase_nxt = PH_HUNT_FIRST;
          end
        end
        PH_PAYLOAD: begin
          if (in_rx_byte == cfg_i.trailer_first) begin
            phase_nxt = PH_TRAILER;
          end else if (cnt_r < MAX_LEN) begin
            push_o  = 1'b1;
            cnt_nxt = cnt_r + hthd_pkg::LEN_W'(1);
          end else begin
            // overflow: drop packet, byte discarded
            phase_nxt = PH_HUNT_FIRST;
          end
        end
        PH_TRAILER: begin
          if (in_rx_byte == cfg_i.trailer_second) begin
            push_o          = 1'b1;
            push_cmd_o.op   = hthd_pkg::CMD_DELIVER;
          end
          phase_nxt = PH_HUNT_FIRST;
        end
        default: phase_nxt = PH_HUNT_FIRST;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HUNT_FIRST;
      cnt_r   <= '0;
    end else begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

FILE: design/hthd_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hthd_queue - short command queue
// Two-entry FIFO decoupling the parser from the payload engine.
// ----------------------------------------------------------------------------
module hthd_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push_i,
  input  hthd_pkg::cmd_t push_cmd_i,
  input  logic           pop_i,
  output hthd_pkg::cmd_t head_o,
  output logic           empty_o,
  output logic           full_o
);

  hthd_pkg::cmd_t              entry_r [hthd_pkg::Q_DEPTH];
  logic [hthd_pkg::Q_AW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [hthd_pkg::Q_AW:0]     fill_r;

  assign head_o  = entry_r[rd_ptr_r];
  assign empty_o = (fill_r == '0);
  assign full_o  = (fill_r == (hthd_pkg::Q_AW + 1)'(hthd_pkg::Q_DEPTH));

  // storage
  always_ff @(posedge clk) begin
    if (push_i) entry_r[wr_ptr_r] <= push_cmd_i;
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      if (push_i) wr_ptr_r <= wr_ptr_r + hthd_pkg::Q_AW'(1);
      if (pop_i)  rd_ptr_r <= rd_ptr_r + hthd_pkg::Q_AW'(1);
      if (push_i && !pop_i)      fill_r <= fill_r + (hthd_pkg::Q_AW + 1)'(1);
      else if (pop_i && !push_i) fill_r <= fill_r - (hthd_pkg::Q_AW + 1)'(1);
    end
  end

endmodule

FILE: design/hthd_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hthd_back - payload engine
// Executes queued commands: writes payload bytes into the buffer memory and
// drains a confirmed packet, one registered read per result.
// ----------------------------------------------------------------------------
module hthd_back #(
  parameter int MAX_PAYLOAD = 64
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  hthd_pkg::cmd_t              head_i,
  input  logic                        empty_i,
  output logic                        pop_o,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [hthd_pkg::BYTE_W-1:0] out_payload_byte,
  output logic [hthd_pkg::IDX_W-1:0]  out_byte_index,
  output logic [hthd_pkg::LEN_W-1:0]  out_packet_length,
  output logic                        out_empty_packet,
  output logic                        out_last_of_packet
);

  localparam int ADDR_W = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

  typedef enum logic [1:0] {
    BK_IDLE  = 2'b01,
    BK_DRAIN = 2'b10
  } bk_state_t;

  bk_state_t                   state_r, state_nxt;
  logic                        pend_r, pend_nxt;
  logic [hthd_pkg::LEN_W-1:0]  len_r, len_nxt;
  logic [hthd_pkg::LEN_W-1:0]  k_r, k_nxt, k_inc;
  logic                        out_free;

  logic [hthd_pkg::BYTE_W-1:0] mem [MAX_PAYLOAD];
  logic [hthd_pkg::BYTE_W-1:0] rd_data_r;
  logic                        wr_en, rd_en;

  logic                        valid_r, valid_nxt;
  logic                        load_byte, load_empty;
  logic [hthd_pkg::BYTE_W-1:0] byte_r;
  logic [hthd_pkg::IDX_W-1:0]  idx_r;
  logic [hthd_pkg::LEN_W-1:0]  olen_r;
  logic                        empty_r, last_r;

  assign out_free = !valid_r || out_ready;
  assign k_inc    = k_r + hthd_pkg::LEN_W'(1);

  // command execution and drain sequencing
  always_comb begin
    state_nxt  = state_r;
    pend_nxt   = pend_r;
    len_nxt    = len_r;
    k_nxt      = k_r;
    pop_o      = 1'b0;
    wr_en      = 1'b0;
    rd_en      = 1'b0;
    load_byte  = 1'b0;
    load_empty = 1'b0;
    unique case (state_r)
      BK_IDLE: begin
        if (!empty_i) begin
          if (head_i.op == hthd_pkg::CMD_STORE) begin
            pop_o = 1'b1;
            wr_en = 1'b1;
          end else if (out_free) begin
            pop_o = 1'b1;
            if (head_i.count == '0) begin
              load_empty = 1'b1;
            end else begin
              state_nxt = BK_DRAIN;
              len_nxt   = head_i.count;
              k_nxt     = '0;
              pend_nxt  = 1'b0;
            end
          end
        end
      end
      BK_DRAIN: begin
        if (pend_r) begin
          // read data back: output register is free by construction
          load_byte = 1'b1;
          pend_nxt  = 1'b0;
          k_nxt     = k_inc;
          if (k_inc == len_r) state_nxt = BK_IDLE;
        end else if (out_free) begin
          rd_en    = 1'b1;
          pend_nxt = 1'b1;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  // payload buffer memory
  always_ff @(posedge clk) begin
    if (wr_en) mem[head_i.count[ADDR_W-1:0]] <= head_i.data;
    if (rd_en) rd_data_r <= mem[k_r[ADDR_W-1:0]];
  end

  // output register
  always_comb begin
    valid_nxt = valid_r;
    if (load_byte || load_empty) valid_nxt = 1'b1;
    else if (out_ready)          valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (load_empty) begin
      byte_r  <= '0;
      idx_r   <= '0;
      olen_r  <= '0;
      empty_r <= 1'b1;
      last_r  <= 1'b1;
    end else if (load_byte) begin
      byte_r  <= rd_data_r;
      idx_r   <= k_r[hthd_pkg::IDX_W-1:0];
      olen_r  <= len_r;
      empty_r <= 1'b0;
      last_r  <= (k_inc == len_r);
    end
  end

  always_ff @(posedge clk) begin
    len_r <= len_nxt;
    k_r   <= k_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
      pend_r  <= 1'b0;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pend_r  <= pend_nxt;
      valid_r <= valid_nxt;
    end
  end

  assign out_valid          = valid_r;
  assign out_payload_byte   = byte_r;
  assign out_byte_index     = idx_r;
  assign out_packet_length  = olen_r;
  assign out_empty_packet   = empty_r;
  assign out_last_of_packet = last_r;

endmodule
